// ----- sv/scsr_pkg.sv -----
// shared types and constants for the serial command sensor reporter
`default_nettype none

package scsr_pkg;

  // frame delimiters and ascii digit base
  localparam logic [7:0] CharHash = 8'h23;
  localparam logic [7:0] CharStar = 8'h2A;
  localparam logic [7:0] CharZero = 8'h30;

  // sensor channels and keywords
  localparam int unsigned NumChannels = 5;
  localparam int unsigned KeyCount    = 6;
  localparam int unsigned KeyMaxLen   = 14;
  localparam logic [2:0]  NoChannel   = 3'd5;

  // width of the sample and of its decimal form
  localparam int unsigned SampleW = 12;
  localparam int unsigned BcdW    = 16;

  // keyword text without the closing star, right aligned
  localparam logic [8*KeyMaxLen-1:0] KeyText [KeyCount] = '{
    (8*KeyMaxLen)'("#TEMP"),
    (8*KeyMaxLen)'("#ANEMOMETER"),
    (8*KeyMaxLen)'({"#RAIN_", "DROP"}),
    (8*KeyMaxLen)'({"#SOIL_", "MOISTURE"}),
    (8*KeyMaxLen)'({"#UV_", "LEVEL"}),
    (8*KeyMaxLen)'("#OFF")
  };

  localparam int unsigned KeyLen [KeyCount] = '{5, 11, 10, 14, 9, 4};

  localparam logic [4:0] KeyLeds [KeyCount] = '{
    5'h10, 5'h08, 5'h04, 5'h02, 5'h01, 5'h00
  };

  localparam logic [2:0] KeyChan [KeyCount] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, NoChannel
  };

  // status of the serial decimal converter
  typedef struct packed {
    logic busy;
    logic done;
  } bcd_stat_t;

  // character p of keyword k, zero past its end
  function automatic logic [7:0] key_byte(input int unsigned k, input int unsigned p);
    logic [8*KeyMaxLen-1:0] txt;
    int unsigned            len;
    txt = KeyText[k];
    len = KeyLen[k];
    if (p < len) begin
      key_byte = txt[8*(len-1-p) +: 8];
    end else begin
      key_byte = 8'h00;
    end
  endfunction

endpackage

`default_nettype wire

// ----- sv/scsr_bcd.sv -----
// bit-serial binary to decimal converter (shift and add three)
`default_nettype none

module scsr_bcd
  import scsr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [SampleW-1:0] value_i,
  output bcd_stat_t               stat_o,
  output logic [BcdW-1:0]         bcd_o
);

  localparam int unsigned CntW = $clog2(SampleW + 1);

  logic [SampleW-1:0] bin_q;
  logic [BcdW-1:0]    bcd_q;
  logic [BcdW-1:0]    adj;
  logic [CntW-1:0]    cnt_q;
  logic               busy_q;
  logic               done_q;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < BcdW / 4; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // one binary bit enters the decimal shift register per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q  <= '0;
      bcd_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        bin_q  <= value_i;
        bcd_q  <= '0;
        cnt_q  <= CntW'(SampleW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        bcd_q <= {adj[BcdW-2:0], bin_q[SampleW-1]};
        bin_q <= {bin_q[SampleW-2:0], 1'b0};
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign bcd_o       = bcd_q;

endmodule

`default_nettype wire

// ----- sv/serial_command_sensor_reporter_core.sv -----
// serial command frame parser with decimal sensor reply
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i / in_ready_o, operation_i,     | into block
//           | rx_char_i, sample_channel_i,              |
//           | sample_value_i                            |
//   out     | out_valid_o / out_ready_i, tx_char_o,     | out of block
//           | last_char_o, led_pattern_o                |
//
// a byte or sample update is taken only while idle; keywords are matched as bytes arrive
// a matched frame runs the bit-serial decimal converter, then
// gives one digit per cycle while out_ready_i is high (up to 4 digits)
// in_ready_o is low until the reply is sent
// reset clears the frame state, the samples and the indicators
// a stalled output simply holds the current digit
`default_nettype none

module serial_command_sensor_reporter_core
  import scsr_pkg::*;
#(
  parameter int unsigned FRAME_CAPACITY = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic         operation_i,
  input  wire logic [7:0]   rx_char_i,
  input  wire logic [2:0]   sample_channel_i,
  input  wire logic [11:0]  sample_value_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [7:0]        tx_char_o,
  output logic              last_char_o,
  output logic [4:0]        led_pattern_o
);

  localparam int unsigned     PosW   = $clog2(FRAME_CAPACITY + 1);
  localparam logic [PosW-1:0] CapPos = PosW'(FRAME_CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_e;

  state_e             state_q;
  logic [PosW-1:0]    pos_q;
  logic               ovf_q;
  logic [KeyCount-1:0] match_q;
  logic [SampleW-1:0] samples_q [NumChannels];
  logic [4:0]         leds_q;
  logic [BcdW-1:0]    digits_q;
  logic [2:0]         left_q;

  logic               accept;
  logic               is_byte;
  logic               is_close;
  logic               hit_any;
  logic [4:0]         hit_leds;
  logic [2:0]         hit_chan;
  logic               conv_start;
  logic [SampleW-1:0] conv_value;
  bcd_stat_t          conv_stat;
  logic [BcdW-1:0]    conv_bcd;

  assign accept   = in_valid_i && in_ready_o;
  assign is_byte  = !operation_i && (rx_char_i != 8'h00);
  assign is_close = is_byte && (rx_char_i == CharStar) && (pos_q != '0);

  // keyword hit: still matching and frame length equals keyword length
  always_comb begin
    hit_any  = 1'b0;
    hit_leds = '0;
    hit_chan = NoChannel;
    for (int k = 0; k < KeyCount; k++) begin
      if (match_q[k] && (int'(pos_q) == KeyLen[k])) begin
        hit_any  = 1'b1;
        hit_leds = KeyLeds[k];
        hit_chan = KeyChan[k];
      end
    end
  end

  assign conv_start = accept && is_close && hit_any && !ovf_q;
  assign conv_value = (hit_chan != NoChannel) ? samples_q[hit_chan] : '0;

  scsr_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .value_i (conv_value),
    .stat_o  (conv_stat),
    .bcd_o   (conv_bcd)
  );

  // frame tracking, sample store and reply sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pos_q    <= '0;
      ovf_q    <= 1'b0;
      match_q  <= '0;
      leds_q   <= '0;
      digits_q <= '0;
      left_q   <= '0;
      for (int i = 0; i < NumChannels; i++) begin
        samples_q[i] <= '0;
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (operation_i) begin
              if (sample_channel_i < 3'(NumChannels)) begin
                samples_q[sample_channel_i] <= sample_value_i;
              end
            end else if (is_byte) begin
              if (rx_char_i == CharHash) begin
                pos_q   <= PosW'(1);
                ovf_q   <= 1'b0;
                match_q <= '1;
              end else if (pos_q != '0) begin
                if (rx_char_i == CharStar) begin
                  pos_q <= '0;
                  ovf_q <= 1'b0;
                  if (conv_start) begin
                    leds_q  <= hit_leds;
                    state_q <= ST_CONV;
                  end
                end else if (pos_q < CapPos) begin
                  for (int k = 0; k < KeyCount; k++) begin
                    match_q[k] <= match_q[k] &&
                                  (rx_char_i == key_byte(k, int'(pos_q)));
                  end
                  pos_q <= pos_q + PosW'(1);
                end else begin
                  ovf_q <= 1'b1;
                end
              end
            end
          end
        end
        ST_CONV: begin
          // drop leading zeros, keep at least one digit
          if (conv_stat.done) begin
            state_q <= ST_EMIT;
            if (conv_bcd[15:12] != 4'd0) begin
              digits_q <= conv_bcd;
              left_q   <= 3'd4;
            end else if (conv_bcd[11:8] != 4'd0) begin
              digits_q <= {conv_bcd[11:0], 4'd0};
              left_q   <= 3'd3;
            end else if (conv_bcd[7:4] != 4'd0) begin
              digits_q <= {conv_bcd[7:0], 8'd0};
              left_q   <= 3'd2;
            end else begin
              digits_q <= {conv_bcd[3:0], 12'd0};
              left_q   <= 3'd1;
            end
          end
        end
        ST_EMIT: begin
          if (out_ready_i) begin
            digits_q <= {digits_q[BcdW-5:0], 4'd0};
            left_q   <= left_q - 3'd1;
            if (left_q == 3'd1) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_EMIT);
  assign tx_char_o     = CharZero | {4'd0, digits_q[BcdW-1 -: 4]};
  assign last_char_o   = (left_q == 3'd1);
  assign led_pattern_o = leds_q;

`ifndef NO_ASSERTIONS
  // input is held off while a reply is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input accepted during reply");

  // the final digit hands control back to the input side
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_char_o) |=> in_ready_o)
    else $error("block not idle after last digit");

  // converter only finishes while the sequencer waits for it
  a_done_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_stat.done |-> (state_q == ST_CONV))
    else $error("conversion done outside conversion state");

  // converter only runs while the sequencer waits for it
  a_busy_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_stat.busy |-> (state_q == ST_CONV))
    else $error("conversion running outside conversion state");

  // every transmitted character is a decimal digit
  a_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tx_char_o[7:4] == 4'h3 && tx_char_o[3:0] <= 4'd9))
    else $error("non-digit character");

  // at most one indicator lit
  a_one_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(led_pattern_o))
    else $error("more than one indicator lit");
`endif

endmodule

`default_nettype wire
